// ===== hw/rtl/lkv_pkg.sv =====
// shared types and constants of the lru key-value cache
// no dependencies; used by lkv_ram and lru_key_value_cache
package lkv_pkg;

    localparam int KeyW   = 10;
    localparam int ValW   = 31;
    localparam int RdW    = 32;
    localparam int CapW   = 7;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic signed [RdW-1:0] READ_MISS = '1;

    typedef struct packed {
        logic            command;
        logic [KeyW-1:0] lookup_key;
        logic [ValW-1:0] write_value;
    } lkv_req_t;

    typedef struct packed {
        logic                   hit;
        logic signed [RdW-1:0]  read_value;
        logic                   evicted;
        logic [KeyW-1:0]        evicted_key;
    } lkv_rsp_t;

endpackage

// ===== hw/rtl/lkv_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// depends on lkv_pkg only by convention of the project
module lkv_ram
    import lkv_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// lru key-value cache top level: key map ram, three slot rams, control
// depends on lkv_pkg and lkv_ram
//
// usage
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes entry_capacity; always ready
//   in channel carries one get or put transaction; out channel one result each
//   a key map ram (presence, slot, value per key) and three slot rams (key,
//   older link, newer link) hold all state; each request reads them, and puts and relinking hits rewrite them
// result path and rate
//   every request: the look-up state writes the result into the holding register,
//   which moves on to the out register (out_valid) when out is not stalled
//   the next transaction also waits for S_LINK and S_LINK2 in a hit that relinks
//   one request in flight at a time; the sequence of dependent ram accesses
//   (key map read, then link reads, then link writes) sets the rate
// reset
//   control registers clear, capacity returns to 64, then a clearing pass over all
//   KEY_SPACE entries zeroes the key map; in_ready stays low during it
// stall
//   a result waits in a holding register while out is stalled; the next
//   transaction is taken once that holding register is empty
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int KEY_SPACE   = 1024,
    parameter int MAX_ENTRIES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CapW-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  lkv_req_t        in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output lkv_rsp_t        out_data
);

    // key space is taken as a power of two; keys wrap on the low bits
    localparam int KW  = $clog2(KEY_SPACE);
    localparam int SW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int EW  = (CW > CapW) ? CW : CapW;
    localparam int KDW = 1 + SW + ValW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_LINK  = 3'd3;
    localparam logic [2:0] S_LINK2 = 3'd4;
    localparam logic [2:0] S_EVCL  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [KW-1:0]   clr_idx_reg;
    logic [CapW-1:0] cap_reg;
    logic [SW-1:0]   oldest_reg, oldest_next;
    logic [SW-1:0]   newest_reg, newest_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [KW-1:0]   key_reg;
    logic [KW-1:0]   evkey_reg, evkey_next;
    logic            put_reg;
    logic [ValW-1:0] val_reg;
    logic            pend_valid_reg, pend_valid_next;
    lkv_rsp_t        pend_data_reg, pend_data_next;
    logic            out_valid_reg;
    lkv_rsp_t        out_data_reg;

    // ram ports
    logic            k_we;
    logic [KW-1:0]   k_waddr, k_raddr;
    logic [KDW-1:0]  k_wdata, k_rdata;
    logic            sk_we, so_we, sn_we;
    logic [SW-1:0]   sk_waddr, so_waddr, sn_waddr, s_raddr;
    logic [KW-1:0]   sk_wdata, sk_rdata;
    logic [SW-1:0]   so_wdata, so_rdata, sn_wdata, sn_rdata;

    logic            k_present;
    logic [SW-1:0]   k_slot;
    logic [ValW-1:0] k_value;
    logic [EW-1:0]   eff_cap;
    logic            evict;
    logic [CW-1:0]   count_dec;
    logic [SW-1:0]   new_slot;

    assign k_present = k_rdata[KDW-1];
    assign k_slot    = k_rdata[ValW +: SW];
    assign k_value   = k_rdata[ValW-1:0];

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = EW'(1);
        end
        else if (EW'(cap_reg) > EW'(MAX_ENTRIES))
        begin
            eff_cap = EW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = EW'(cap_reg);
        end
    end

    assign evict     = (EW'(count_reg) >= eff_cap) && (count_reg != '0);
    assign count_dec = evict ? count_reg - CW'(1) : count_reg;
    assign new_slot  = k_present ? k_slot : (evict ? oldest_reg : count_reg[SW-1:0]);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !pend_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign k_raddr = KW'(in_data.lookup_key);
    assign s_raddr = (state_reg == S_LOOK) ? k_slot : oldest_reg;

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        evkey_next      = evkey_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        k_we     = 1'b0;
        k_waddr  = key_reg;
        k_wdata  = '0;
        sk_we    = 1'b0;
        sk_waddr = new_slot;
        sk_wdata = key_reg;
        so_we    = 1'b0;
        so_waddr = new_slot;
        so_wdata = newest_reg;
        sn_we    = 1'b0;
        sn_waddr = newest_reg;
        sn_wdata = new_slot;

        if (pend_valid_reg && (!out_valid_reg || out_ready))
        begin
            pend_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                k_we    = 1'b1;
                k_waddr = clr_idx_reg;
                if (clr_idx_reg == KW'(KEY_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                pend_valid_next            = 1'b1;
                pend_data_next.hit         = k_present;
                pend_data_next.read_value  = (k_present && put_reg == CMD_GET)
                                           ? {1'b0, k_value} : READ_MISS;
                pend_data_next.evicted     = 1'b0;
                pend_data_next.evicted_key = '0;
                slot_next                  = k_slot;
                if (put_reg == CMD_PUT)
                begin
                    k_we    = 1'b1;
                    k_wdata = {1'b1, new_slot, val_reg};
                end
                if (k_present)
                begin
                    state_next = (k_slot == newest_reg) ? S_IDLE : S_LINK;
                end
                else if (put_reg == CMD_GET)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sk_we = 1'b1;
                    if (evict)
                    begin
                        pend_data_next.evicted     = 1'b1;
                        pend_data_next.evicted_key = KeyW'(sk_rdata);
                        evkey_next                 = sk_rdata;
                        if (count_reg > CW'(1))
                        begin
                            oldest_next = sn_rdata;
                        end
                        state_next = S_EVCL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                    if (count_dec == '0)
                    begin
                        oldest_next = new_slot;
                    end
                    else
                    begin
                        so_we = 1'b1;
                        sn_we = 1'b1;
                    end
                    newest_next = new_slot;
                    count_next  = count_dec + CW'(1);
                end
            end
            S_LINK:
            begin
                // unlink: data here is older and newer neighbour of the slot
                if (slot_reg == oldest_reg)
                begin
                    oldest_next = sn_rdata;
                end
                else
                begin
                    sn_we    = 1'b1;
                    sn_waddr = so_rdata;
                    sn_wdata = sn_rdata;
                    so_we    = 1'b1;
                    so_waddr = sn_rdata;
                    so_wdata = so_rdata;
                end
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                so_we       = 1'b1;
                so_waddr    = slot_reg;
                so_wdata    = newest_reg;
                sn_we       = 1'b1;
                sn_waddr    = newest_reg;
                sn_wdata    = slot_reg;
                newest_next = slot_reg;
                state_next  = S_IDLE;
            end
            S_EVCL:
            begin
                k_we       = 1'b1;
                k_waddr    = evkey_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            cap_reg        <= CapW'(64);
            oldest_reg     <= '0;
            newest_reg     <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            newest_reg     <= newest_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + KW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        evkey_reg     <= evkey_next;
        pend_data_reg <= pend_data_next;
        if (in_valid && in_ready)
        begin
            key_reg <= KW'(in_data.lookup_key);
            put_reg <= in_data.command;
            val_reg <= in_data.write_value;
        end
        if (pend_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_data_reg <= pend_data_reg;
        end
    end

    lkv_ram #(.WIDTH(KDW), .DEPTH(KEY_SPACE)) u_key_map (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    lkv_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_slot_key (
        .clk   (clk),
        .we    (sk_we),
        .waddr (sk_waddr),
        .wdata (sk_wdata),
        .raddr (s_raddr),
        .rdata (sk_rdata)
    );

    lkv_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_slot_older (
        .clk   (clk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (so_wdata),
        .raddr (s_raddr),
        .rdata (so_rdata)
    );

    lkv_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_slot_newer (
        .clk   (clk),
        .we    (sn_we),
        .waddr (sn_waddr),
        .wdata (sn_wdata),
        .raddr (s_raddr),
        .rdata (sn_rdata)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above slot count");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LOOK))
        else $error("accepted transaction not looked up");

    a_link_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK2) |-> ($past(state_reg) == S_LINK))
        else $error("relink second step without first");

    a_pend_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> !pend_valid_reg)
        else $error("result holding register overwritten");
`endif

endmodule

// ===== verif/tb_lru_key_value_cache.sv =====
// self-checking testbench of the lru key-value cache: directed table, then random traffic
// depends on lkv_pkg and the lru_key_value_cache rtl
module tb_lru_key_value_cache;
    import lkv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS = 1024;
    localparam int NSLOTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CapW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    lkv_req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    lkv_rsp_t out_data;

    always #4 clk = ~clk;

    lru_key_value_cache u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // shadow cache state
    bit              key_present [NKEYS];
    logic [ValW-1:0] key_value [NKEYS];
    int unsigned     key_slot [NKEYS];
    int unsigned     slot_owner [NSLOTS];
    int unsigned     slot_prev [NSLOTS];
    int unsigned     slot_next [NSLOTS];
    int unsigned     lru_slot, mru_slot, live_count;
    logic [CapW-1:0] capacity_reg;

    lkv_rsp_t pending_rsp[$];
    int  fail_count = 0;
    int  send_idle_pct = 0, recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  quiet_cycles = 0;

    function automatic int unsigned eff_capacity();
        if (capacity_reg == 0) return 1;
        if (capacity_reg > NSLOTS) return NSLOTS;
        return capacity_reg;
    endfunction

    function automatic void promote_slot(int unsigned s);
        int unsigned o, n;
        if (s == mru_slot) return;
        if (s == lru_slot)
            lru_slot = slot_next[s];
        else
        begin
            o = slot_prev[s];
            n = slot_next[s];
            slot_next[o] = n;
            slot_prev[n] = o;
        end
        slot_prev[s] = mru_slot;
        slot_next[mru_slot] = s;
        mru_slot = s;
    endfunction

    function automatic lkv_rsp_t predict_lookup(lkv_req_t rq);
        lkv_rsp_t r;
        int unsigned k, s;
        k = rq.lookup_key;
        r.hit = key_present[k];
        r.read_value = READ_MISS;
        r.evicted = 1'b0;
        r.evicted_key = '0;
        if (rq.command == CMD_GET)
        begin
            if (key_present[k])
            begin
                r.read_value = {1'b0, key_value[k]};
                promote_slot(key_slot[k]);
            end
        end
        else if (key_present[k])
        begin
            key_value[k] = rq.write_value;
            promote_slot(key_slot[k]);
        end
        else
        begin
            if (live_count >= eff_capacity() && live_count > 0)
            begin
                s = lru_slot;
                r.evicted = 1'b1;
                r.evicted_key = KeyW'(slot_owner[s]);
                key_present[slot_owner[s]] = 1'b0;
                if (live_count > 1) lru_slot = slot_next[s];
                live_count--;
            end
            else
                s = live_count % NSLOTS;
            slot_owner[s] = k;
            key_slot[k] = s;
            key_present[k] = 1'b1;
            key_value[k] = rq.write_value;
            if (live_count == 0)
            begin
                lru_slot = s;
                mru_slot = s;
            end
            else
            begin
                slot_next[mru_slot] = s;
                slot_prev[s] = mru_slot;
                mru_slot = s;
            end
            live_count++;
        end
        return r;
    endfunction

    // result checking at the rising edge
    always @(posedge clk)
    begin
        lkv_rsp_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (out_valid && out_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (out_data.hit !== want.hit)
                begin
                    $error("hit: expected %0d actual %0d", want.hit, out_data.hit);
                    fail_count++;
                end
                if (out_data.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d actual %0d",
                           want.read_value, out_data.read_value);
                    fail_count++;
                end
                if (out_data.evicted !== want.evicted)
                begin
                    $error("evicted: expected %0d actual %0d", want.evicted, out_data.evicted);
                    fail_count++;
                end
                if (out_data.evicted_key !== want.evicted_key)
                begin
                    $error("evicted_key: expected %0d actual %0d",
                           want.evicted_key, out_data.evicted_key);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_lru_key_value_cache: FAIL");
            $finish;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n || recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // send one request; prediction queued at acceptance, optional typed-in check
    // valid stays high into the next request unless the sender idles
    task automatic send_request(lkv_req_t rq, bit typed, lkv_rsp_t typed_rsp);
        lkv_rsp_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= rq;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = predict_lookup(rq);
        if (typed && p !== typed_rsp)
        begin
            $error("directed row: expected %p predicted %p", typed_rsp, p);
            fail_count++;
        end
        pending_rsp.push_back(p);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CapW-1:0] c);
        drain_results();
        cfg_data <= c;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        capacity_reg = c;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic lkv_req_t mk_req(logic c, int unsigned k, logic [ValW-1:0] v);
        lkv_req_t r;
        r.command = c;
        r.lookup_key = KeyW'(k);
        r.write_value = v;
        return r;
    endfunction

    function automatic lkv_rsp_t mk_rsp(logic h, logic signed [RdW-1:0] rv, logic e,
                                        int unsigned ek);
        lkv_rsp_t r;
        r.hit = h;
        r.read_value = rv;
        r.evicted = e;
        r.evicted_key = KeyW'(ek);
        return r;
    endfunction

    typedef struct {
        lkv_req_t req;
        bit       typed;
        lkv_rsp_t rsp;
    } table_row_t;

    task automatic random_phase(int n, int key_range, int put_pct);
        lkv_req_t rq;
        for (int i = 0; i < n; i++)
        begin
            rq.command = ($urandom_range(99) < put_pct) ? CMD_PUT : CMD_GET;
            rq.lookup_key = ($urandom_range(9) == 0) ? KeyW'($urandom_range(NKEYS - 1))
                                                     : KeyW'($urandom_range(key_range - 1));
            rq.write_value = ValW'($urandom());
            send_request(rq, 1'b0, '0);
        end
    endtask

    initial
    begin
        table_row_t rows[$];
        lkv_rsp_t none;
        int hold_len;
        none = '0;
        capacity_reg = 64;
        live_count = 0;
        lru_slot = 0;
        mru_slot = 0;
        foreach (key_present[i]) key_present[i] = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed table: extremes of fields, both commands
        rows.push_back('{mk_req(CMD_GET, 0, 0), 1, mk_rsp(0, READ_MISS, 0, 0)});
        rows.push_back('{mk_req(CMD_GET, 1023, '1), 1, mk_rsp(0, READ_MISS, 0, 0)});
        rows.push_back('{mk_req(CMD_PUT, 1023, '1), 1, mk_rsp(0, READ_MISS, 0, 0)});
        rows.push_back('{mk_req(CMD_GET, 1023, 0), 1, mk_rsp(1, 32'h7fff_ffff, 0, 0)});
        rows.push_back('{mk_req(CMD_PUT, 0, 0), 1, mk_rsp(0, READ_MISS, 0, 0)});
        rows.push_back('{mk_req(CMD_GET, 0, '1), 1, mk_rsp(1, 0, 0, 0)});
        rows.push_back('{mk_req(CMD_PUT, 1023, 5), 1, mk_rsp(1, READ_MISS, 0, 0)});
        rows.push_back('{mk_req(CMD_PUT, 512, 31'h2aaa_aaaa), 0, none});
        rows.push_back('{mk_req(CMD_GET, 0, 0), 0, none});
        rows.push_back('{mk_req(CMD_GET, 512, 0), 0, none});
        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);

        // lower capacity below the count: each new put evicts one
        write_capacity(1);
        rows.delete();
        rows.push_back('{mk_req(CMD_PUT, 7, 1), 0, none});
        rows.push_back('{mk_req(CMD_PUT, 8, 2), 0, none});
        rows.push_back('{mk_req(CMD_GET, 7, 0), 0, none});
        rows.push_back('{mk_req(CMD_PUT, 9, 3), 0, none});
        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);
        write_capacity(0);
        rows.delete();
        rows.push_back('{mk_req(CMD_PUT, 10, 4), 0, none});
        rows.push_back('{mk_req(CMD_GET, 10, 0), 0, none});
        rows.push_back('{mk_req(CMD_PUT, 11, 5), 0, none});
        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);
        write_capacity(127);
        rows.delete();
        rows.push_back('{mk_req(CMD_GET, 11, 0), 0, none});
        rows.push_back('{mk_req(CMD_PUT, 12, 6), 0, none});
        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);

        // random traffic, receiver-heavy idling first
        send_idle_pct = 22;
        recv_idle_pct = 47;
        write_capacity(64);
        random_phase(300, 128, 50);
        write_capacity(3);
        random_phase(150, 8, 55);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_len = 300 + $urandom_range(200);
                recv_hold = 1'b1;
                repeat (hold_len) @(negedge clk);
                recv_hold = 1'b0;
            end
            random_phase(20, 8, 50);
        join

        send_idle_pct = 47;
        recv_idle_pct = 22;
        write_capacity(16);
        random_phase(300, 40, 50);
        // sender pause until every result is back
        drain_results();
        write_capacity(2);
        random_phase(150, 5, 50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(64);
        random_phase(350, 100, 60);
        write_capacity(CapW'($urandom_range(1, 63)));
        random_phase(300, 64, 50);
        write_capacity(100);
        random_phase(250, NKEYS, 70);

        drain_results();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("tb_lru_key_value_cache: PASS");
        else
            $display("tb_lru_key_value_cache: FAIL");
        $finish;
    end
endmodule
